// ----- rtl/core/tsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the tab-stop column finder: column and
// table widths, configuration register indexes and the register bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  // Table depth and column width
  localparam int unsigned MAX_STOPS   = 64;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned IDX_BITS    = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned CNT_BITS    = $clog2(MAX_STOPS + 1);
  localparam int unsigned STEP_BITS   = $clog2(COLUMN_BITS);

  // Configuration registers are 16 bits wide
  localparam int unsigned REG_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;

  typedef logic [COLUMN_BITS-1:0]  col_t;
  typedef logic [COLUMN_BITS:0]    sum_t;
  typedef logic [IDX_BITS-1:0]     idx_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [STEP_BITS-1:0]    step_t;
  typedef logic [REG_BITS-1:0]     reg_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_UNIFORM   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EXTEND    = cfg_idx_t'(1);
  localparam cfg_idx_t REG_INCREMENT = cfg_idx_t'(2);

  localparam reg_t UNIFORM_RESET = reg_t'(8);

  // Input action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam cnt_t CNT_FULL = cnt_t'(MAX_STOPS);

  // Register bundle handed to the sequencer
  typedef struct packed {
    reg_t uniform_size;
    reg_t extend_width;
    reg_t increment_step;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/tab_stop_column_finder.sv -----
// ----------------------------------------------------------------------------
// tab_stop_column_finder
// Tab-stop engine: appends explicit stop columns and answers, for a current
// column, the column of the next tab stop.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_ready    action, column_value, line_start
//   out      out        out_valid/out_ready  next_column, past_last_stop,
//                                            column_overflow, table_full
//
// An add goes straight to the output register. A uniform-size query runs the
// bit-serial remainder unit. A table query reads and compares one entry at a
// time from the search index, then answers a hit or a past-last directly, or
// runs the remainder unit with an extend size or with an increment.
// One item is in work at a time; a held result stalls only the next result.
// Reset clears counters and registers, not the stop table; cfg_ready stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module tab_stop_column_finder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire tsc_pkg::cfg_idx_t    cfg_index,
  input  wire tsc_pkg::reg_t        cfg_data,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 action,
  input  wire tsc_pkg::col_t        column_value,
  input  wire logic                 line_start,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tsc_pkg::col_t             next_column,
  output logic                      past_last_stop,
  output logic                      column_overflow,
  output logic                      table_full
);

  tsc_pkg::cfg_t  cfg;
  logic           div_start;
  tsc_pkg::col_t  div_dividend;
  tsc_pkg::col_t  div_divisor;
  logic           div_busy;
  logic           div_done;
  tsc_pkg::col_t  div_remainder;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.uniform_size   <= tsc_pkg::UNIFORM_RESET;
      cfg.extend_width   <= '0;
      cfg.increment_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsc_pkg::REG_UNIFORM:   cfg.uniform_size   <= cfg_data;
        tsc_pkg::REG_EXTEND:    cfg.extend_width   <= cfg_data;
        tsc_pkg::REG_INCREMENT: cfg.increment_step <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_remainder)
  );

  tsc_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .column_value    (column_value),
    .line_start      (line_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_column     (next_column),
    .past_last_stop  (past_last_stop),
    .column_overflow (column_overflow),
    .table_full      (table_full),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_remainder   (div_remainder)
  );

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("remainder unit busy while taking a new item");

  a_div_done_not_ready: assert property (@(posedge clk) disable iff (rst)
    div_done |-> !in_ready)
    else $error("remainder finished with no query in work");

  a_start_not_ready: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !in_ready)
    else $error("remainder unit started with no query in work");

endmodule

`default_nettype wire

// ----- rtl/core/tsc_divider.sv -----
// ----------------------------------------------------------------------------
// tsc_divider
// Restoring remainder unit: one quotient bit per cycle. Holds the remainder
// after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire tsc_pkg::col_t     dividend,
  input  wire tsc_pkg::col_t     divisor,
  output logic                   busy,
  output logic                   done,
  output tsc_pkg::col_t          remainder
);

  tsc_pkg::step_t       step;
  tsc_pkg::col_t        quot;
  tsc_pkg::col_t        dvsr;
  tsc_pkg::sum_t        trial;
  tsc_pkg::sum_t        diff;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    trial = {remainder, quot[tsc_pkg::COLUMN_BITS-1]};
    diff  = trial - {1'b0, dvsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= tsc_pkg::step_t'(tsc_pkg::COLUMN_BITS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - tsc_pkg::step_t'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot      <= dividend;
      dvsr      <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quot <= {quot[tsc_pkg::COLUMN_BITS-2:0], 1'b0};
      if (!diff[tsc_pkg::COLUMN_BITS]) begin
        remainder <= diff[tsc_pkg::COLUMN_BITS-1:0];
      end else begin
        remainder <= trial[tsc_pkg::COLUMN_BITS-1:0];
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dvsr))
    else $error("remainder not below divisor");

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire

// ----- rtl/core/tsc_seq.sv -----
// ----------------------------------------------------------------------------
// tsc_seq
// Sequencer of the tab-stop finder: holds the stop table, walks it one
// entry at a time through a read and a compare state, drives the shared
// remainder unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsc_pkg::cfg_t     cfg,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              action,
  input  wire tsc_pkg::col_t     column_value,
  input  wire logic              line_start,
  // output channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsc_pkg::col_t          next_column,
  output logic                   past_last_stop,
  output logic                   column_overflow,
  output logic                   table_full,
  // remainder unit
  output logic                   div_start,
  output tsc_pkg::col_t          div_dividend,
  output tsc_pkg::col_t          div_divisor,
  input  wire logic              div_done,
  input  wire tsc_pkg::col_t     div_remainder
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_RD, S_WALK_CMP, S_LAST_RD, S_LAST_CMP, S_DIV_START, S_DIV,
    S_FINISH, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    M_UNIFORM, M_EXTEND, M_INC_FWD, M_INC_BACK, M_PAST
  } mode_t;

  state_t         state;
  mode_t          mode;
  tsc_pkg::cnt_t  stop_count;
  tsc_pkg::cnt_t  search_index;
  tsc_pkg::col_t  col;
  tsc_pkg::col_t  res_col;
  logic           res_past;
  logic           res_ovf;
  logic           res_full;

  tsc_pkg::col_t  stop_table [tsc_pkg::MAX_STOPS];
  tsc_pkg::col_t  rd_data;
  tsc_pkg::idx_t  rd_addr;
  logic           wr_en;

  logic           accept;
  logic           add_full;
  tsc_pkg::col_t  last_stop;
  tsc_pkg::col_t  delta;
  tsc_pkg::col_t  size_sel;
  tsc_pkg::sum_t  sum;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign add_full  = (stop_count >= tsc_pkg::CNT_FULL);
  assign wr_en     = accept && (action == tsc_pkg::ACT_ADD) && !add_full;
  assign div_start = (state == S_DIV_START);

  // Read the last stop for the increment case, otherwise the walk entry
  always_comb begin
    if (state == S_LAST_RD) begin
      rd_addr = tsc_pkg::IDX_BITS'(stop_count - tsc_pkg::cnt_t'(1));
    end else begin
      rd_addr = search_index[tsc_pkg::IDX_BITS-1:0];
    end
  end

  // Stop table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stop_table[stop_count[tsc_pkg::IDX_BITS-1:0]] <= column_value;
    end
    rd_data <= stop_table[rd_addr];
  end

  // An empty table counts increments from column zero
  assign last_stop = (stop_count != '0) ? rd_data : '0;

  // Distance to the next stop once the remainder is known
  always_comb begin
    case (mode)
      M_UNIFORM:  size_sel = cfg.uniform_size;
      M_EXTEND:   size_sel = cfg.extend_width;
      default:    size_sel = cfg.increment_step;
    endcase
    case (mode)
      M_UNIFORM, M_EXTEND, M_INC_FWD: delta = size_sel - div_remainder;
      M_INC_BACK: delta = (div_remainder == '0) ? size_sel : div_remainder;
      default:    delta = tsc_pkg::col_t'(1);
    endcase
    sum = {1'b0, col} + {1'b0, delta};
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stop_count   <= '0;
      search_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            col <= column_value;
            if (action == tsc_pkg::ACT_ADD) begin
              res_col  <= '0;
              res_past <= 1'b0;
              res_ovf  <= 1'b0;
              res_full <= add_full;
              if (!add_full) begin
                stop_count <= stop_count + tsc_pkg::cnt_t'(1);
              end
              state <= S_EMIT;
            end else begin
              if (line_start) begin
                search_index <= '0;
              end
              if (cfg.uniform_size != '0) begin
                div_dividend <= column_value;
                div_divisor  <= cfg.uniform_size;
                mode         <= M_UNIFORM;
                state        <= S_DIV_START;
              end else begin
                state <= S_WALK_RD;
              end
            end
          end
        end
        S_WALK_RD: begin
          if (search_index < stop_count) begin
            state <= S_WALK_CMP;
          end else if (cfg.extend_width != '0) begin
            div_dividend <= col;
            div_divisor  <= cfg.extend_width;
            mode         <= M_EXTEND;
            state        <= S_DIV_START;
          end else if (cfg.increment_step != '0) begin
            state <= S_LAST_RD;
          end else begin
            mode  <= M_PAST;
            state <= S_FINISH;
          end
        end
        S_WALK_CMP: begin
          if (col < rd_data) begin
            res_col  <= rd_data;
            res_past <= 1'b0;
            res_ovf  <= 1'b0;
            res_full <= 1'b0;
            state    <= S_EMIT;
          end else begin
            search_index <= search_index + tsc_pkg::cnt_t'(1);
            state        <= S_WALK_RD;
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_CMP;
        end
        S_LAST_CMP: begin
          div_divisor <= cfg.increment_step;
          if (col >= last_stop) begin
            div_dividend <= col - last_stop;
            mode         <= M_INC_FWD;
          end else begin
            div_dividend <= last_stop - col;
            mode         <= M_INC_BACK;
          end
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          res_ovf  <= sum[tsc_pkg::COLUMN_BITS];
          res_col  <= sum[tsc_pkg::COLUMN_BITS] ? '1 : sum[tsc_pkg::COLUMN_BITS-1:0];
          res_past <= (mode == M_PAST);
          res_full <= 1'b0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            next_column     <= res_col;
            past_last_stop  <= res_past;
            column_overflow <= res_ovf;
            table_full      <= res_full;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    stop_count <= tsc_pkg::CNT_FULL)
    else $error("stop count beyond table depth");

  a_index_within_count: assert property (@(posedge clk) disable iff (rst)
    search_index <= stop_count)
    else $error("search index beyond stop count");

  a_add_grows_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (stop_count == $past(stop_count) + tsc_pkg::cnt_t'(1)))
    else $error("accepted add did not grow the table");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (div_divisor != '0))
    else $error("remainder unit started with zero divisor");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of the tab-stop column finder. Appends and queries are pushed
// into a queue and driven on the input channel with random gaps. Each
// accepted transfer updates a local model of the stop table, the search
// index and the size registers, and that model's answer is queued. The
// monitor stalls the result channel at random and compares every result
// field with the oldest queued answer. Register settings change between
// phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam tsc_pkg::cfg_idx_t REG_SPARE = tsc_pkg::cfg_idx_t'(3);
  localparam longint unsigned COL_LIMIT = (64'd1 << tsc_pkg::COLUMN_BITS) - 1;

  typedef struct packed {
    logic          act;
    tsc_pkg::col_t col;
    logic          ls;
  } stop_item_t;

  typedef struct packed {
    tsc_pkg::col_t next_col;
    logic          past;
    logic          ovf;
    logic          full;
  } stop_result_t;

  // DUT connections
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  tsc_pkg::cfg_idx_t cfg_index = tsc_pkg::REG_UNIFORM;
  tsc_pkg::reg_t     cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = tsc_pkg::ACT_ADD;
  tsc_pkg::col_t     column_value = '0;
  logic              line_start = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tsc_pkg::col_t     next_column;
  logic              past_last_stop;
  logic              column_overflow;
  logic              table_full;

  // Model state
  tsc_pkg::reg_t uniform_reg = tsc_pkg::UNIFORM_RESET;
  tsc_pkg::reg_t extend_reg = '0;
  tsc_pkg::reg_t increment_reg = '0;
  tsc_pkg::col_t stops [tsc_pkg::MAX_STOPS];
  int unsigned   stop_cnt = 0;
  int unsigned   scan_idx = 0;

  stop_item_t   pending_items [$];
  stop_result_t awaited_stops [$];
  stop_item_t   cur_item;
  stop_result_t got_stop;
  stop_result_t want_stop;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b1;
  int unsigned  fails = 0;

  tab_stop_column_finder uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .column_value    (column_value),
    .line_start      (line_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_column     (next_column),
    .past_last_stop  (past_last_stop),
    .column_overflow (column_overflow),
    .table_full      (table_full)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one item to the model and return the result it should produce
  function automatic stop_result_t next_stop_of(logic act, tsc_pkg::col_t col, logic ls);
    stop_result_t    r;
    longint unsigned c;
    longint unsigned delta;
    longint unsigned last;
    longint unsigned m;
    longint unsigned total;
    bit              found;
    r = '0;
    c = col;
    delta = 0;
    found = 1'b0;
    if (act == tsc_pkg::ACT_ADD) begin
      if (stop_cnt >= tsc_pkg::MAX_STOPS) begin
        r.full = 1'b1;
      end else begin
        stops[stop_cnt] = col;
        stop_cnt++;
      end
      return r;
    end
    if (ls) scan_idx = 0;
    if (uniform_reg != 0) begin
      delta = uniform_reg - c % uniform_reg;
    end else begin
      // walk the table from the search index to the first stop past col
      while (!found && scan_idx < stop_cnt) begin
        if (c < stops[scan_idx]) found = 1'b1;
        else scan_idx++;
      end
      if (found) begin
        r.next_col = stops[scan_idx];
        return r;
      end
      if (extend_reg != 0) begin
        delta = extend_reg - c % extend_reg;
      end else if (increment_reg != 0) begin
        // steps count from the last stop, or from zero with an empty table
        last = (stop_cnt > 0) ? stops[stop_cnt - 1] : 0;
        if (c >= last) begin
          m = (c - last) % increment_reg;
        end else begin
          m = (last - c) % increment_reg;
          if (m != 0) m = increment_reg - m;
        end
        delta = increment_reg - m;
      end else begin
        r.past = 1'b1;
        delta = 1;
      end
    end
    total = c + delta;
    if (total > COL_LIMIT) begin
      r.next_col = '1;
      r.ovf = 1'b1;
    end else begin
      r.next_col = tsc_pkg::col_t'(total);
    end
    return r;
  endfunction

  // Track register writes
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsc_pkg::REG_UNIFORM:   uniform_reg <= cfg_data;
        tsc_pkg::REG_EXTEND:    extend_reg <= cfg_data;
        tsc_pkg::REG_INCREMENT: increment_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input driver: predict on each transfer, then present the next item or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        awaited_stops.push_back(next_stop_of(action, column_value, line_start));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          action <= cur_item.act;
          column_value <= cur_item.col;
          line_start <= cur_item.ls;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer, stall ready in short bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_stop = '{next_column, past_last_stop, column_overflow, table_full};
        if (awaited_stops.size() == 0) begin
          $error("result with nothing awaited: next_column %0d", next_column);
          fails++;
        end else begin
          want_stop = awaited_stops.pop_front();
          if (got_stop.next_col !== want_stop.next_col) begin
            $error("next_column: expected %0d, got %0d", want_stop.next_col,
                   got_stop.next_col);
            fails++;
          end
          if (got_stop.past !== want_stop.past) begin
            $error("past_last_stop: expected %0b, got %0b", want_stop.past,
                   got_stop.past);
            fails++;
          end
          if (got_stop.ovf !== want_stop.ovf) begin
            $error("column_overflow: expected %0b, got %0b", want_stop.ovf,
                   got_stop.ovf);
            fails++;
          end
          if (got_stop.full !== want_stop.full) begin
            $error("table_full: expected %0b, got %0b", want_stop.full,
                   got_stop.full);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void push_item(logic act, tsc_pkg::col_t col, logic ls);
    pending_items.push_back('{act, col, ls});
  endfunction

  // Hold until every item is sent and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_stops.size() != 0);
  endtask

  task automatic write_register(tsc_pkg::cfg_idx_t idx, tsc_pkg::reg_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Write all three sizes plus the unused index once the block is idle
  task automatic set_sizes(tsc_pkg::reg_t u, tsc_pkg::reg_t e, tsc_pkg::reg_t i);
    wait_idle();
    write_register(tsc_pkg::REG_UNIFORM, u);
    write_register(tsc_pkg::REG_EXTEND, e);
    write_register(tsc_pkg::REG_INCREMENT, i);
    write_register(REG_SPARE, tsc_pkg::reg_t'($urandom));
    @(negedge clk);
  endtask

  // Fill the rest of the table with ascending stops, ending at the top column
  task automatic fill_table();
    tsc_pkg::col_t col;
    col = '0;
    push_item(tsc_pkg::ACT_ADD, col, 1'($urandom));
    repeat (58) begin
      col = col + tsc_pkg::col_t'($urandom_range(1, 900));
      push_item(tsc_pkg::ACT_ADD, col, 1'($urandom));
    end
    push_item(tsc_pkg::ACT_ADD, '1, 1'($urandom));
  endtask

  // Mostly lines of rising columns, plus stray queries and adds
  task automatic fill_random(int unsigned n);
    int unsigned   made;
    int unsigned   len;
    tsc_pkg::col_t col;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0: begin
          push_item(tsc_pkg::ACT_ADD, tsc_pkg::col_t'($urandom), 1'($urandom));
          made++;
        end
        1, 2: begin
          push_item(tsc_pkg::ACT_QUERY, tsc_pkg::col_t'($urandom), 1'($urandom));
          made++;
        end
        default: begin
          len = $urandom_range(3, 12);
          col = tsc_pkg::col_t'($urandom_range(0, 40));
          for (int unsigned k = 0; k < len; k++) begin
            push_item(tsc_pkg::ACT_QUERY, col, k == 0);
            col = col + tsc_pkg::col_t'($urandom_range(0, 1200));
          end
          made += len;
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Uniform size at its reset value, top-of-range columns
    push_item(tsc_pkg::ACT_QUERY, 16'd0, 1'b1);
    push_item(tsc_pkg::ACT_QUERY, 16'd65527, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd65535, 1'b0);

    // Empty table: increment from column zero, then one step past the end
    set_sizes(16'd0, 16'd0, 16'd5);
    push_item(tsc_pkg::ACT_QUERY, 16'd7, 1'b1);
    push_item(tsc_pkg::ACT_QUERY, 16'd65535, 1'b0);
    set_sizes(16'd0, 16'd0, 16'd0);
    push_item(tsc_pkg::ACT_QUERY, 16'd3, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd65535, 1'b0);
    set_sizes(16'd0, 16'd16, 16'd0);
    push_item(tsc_pkg::ACT_QUERY, 16'd3, 1'b0);

    // Small unordered table, walk it, then a stale search index
    set_sizes(16'd0, 16'd0, 16'd0);
    push_item(tsc_pkg::ACT_ADD, 16'd4, 1'b0);
    push_item(tsc_pkg::ACT_ADD, 16'd10, 1'b1);
    push_item(tsc_pkg::ACT_ADD, 16'd20, 1'b0);
    push_item(tsc_pkg::ACT_ADD, 16'd2, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd0, 1'b1);
    push_item(tsc_pkg::ACT_QUERY, 16'd4, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd15, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd20, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd0, 1'b0);

    // Increment with the last stop above the column, then extend over it
    set_sizes(16'd0, 16'd0, 16'd5);
    push_item(tsc_pkg::ACT_QUERY, 16'd1, 1'b0);
    push_item(tsc_pkg::ACT_QUERY, 16'd22, 1'b0);
    set_sizes(16'd0, 16'd16, 16'd5);
    push_item(tsc_pkg::ACT_QUERY, 16'd22, 1'b0);

    // Random phases over several register settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_sizes(16'd0, 16'd0, 16'd0);
        1: set_sizes(tsc_pkg::reg_t'($urandom_range(1, 64)), tsc_pkg::reg_t'($urandom),
                     tsc_pkg::reg_t'($urandom));
        2: set_sizes(16'd0, tsc_pkg::reg_t'($urandom_range(1, 100)), 16'd0);
        3: set_sizes(16'd0, 16'd0, tsc_pkg::reg_t'($urandom_range(1, 100)));
        4: set_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF);
        5: set_sizes(16'd1, 16'd0, 16'd0);
        6: set_sizes(16'd0, 16'd0, 16'hFFFF);
        default: set_sizes(16'd0, 16'hFFFF, 16'd1);
      endcase
      if (ph == 7) idle_on = 1'b0;
      if (ph == 0) fill_table();
      fill_random(200);
    end

    // Drain, then allow a slow walk to show any stray result
    wait_idle();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tsc_pkg.sv
rtl/core/tsc_divider.sv
rtl/core/tsc_seq.sv
rtl/core/tab_stop_column_finder.sv
test/tb.sv
